// ----- hw/rtl/ivt_pkg.sv -----
// Shared types, register indexes and constants of the isometric vertex transform.
`timescale 1ns / 1ps

package ivt_pkg;

	// Screen geometry; the centre is the truncated half
	localparam int SCREEN_W = 1920;
	localparam int SCREEN_H = 1080;
	localparam int CENTRE_X = SCREEN_W / 2;
	localparam int CENTRE_Y = SCREEN_H / 2;

	// cos 30 in Q1.15; sin 30 is one half and folds into a shift
	localparam logic signed [15:0] COS30_Q15 = 16'sd28378;

	localparam int SAT_MAX = 32767;
	localparam int SAT_MIN = -32768;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_ROT_COS       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROT_SIN       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ALTITUDE_GAIN = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ZOOM_GAIN     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_X       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y       = 3'd5;

	typedef struct packed {
		logic signed [15:0] rot_cos;
		logic signed [15:0] rot_sin;
		logic signed [15:0] altitude_gain;
		logic        [15:0] zoom_gain;
		logic signed [15:0] shift_x;
		logic signed [15:0] shift_y;
	} cfg_t;

	// After rotation: difference and sum of the rotated axes, scaled height
	typedef struct packed {
		logic signed [30:0] diff;
		logic signed [30:0] sum;
		logic signed [31:0] az;
		logic        [23:0] color;
	} rot_t;

	// After projection: px in Q.16 and the negated py in Q.16
	typedef struct packed {
		logic signed [33:0] px;
		logic signed [41:0] npy;
		logic        [23:0] color;
	} proj_t;

endpackage

// ----- hw/rtl/ivt_cfg.sv -----
// Configuration register file of the isometric vertex transform.
`timescale 1ns / 1ps

module ivt_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ivt_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data,
	output ivt_pkg::cfg_t                  cfg
);
	import ivt_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_cos       <= 16'sd16384;
			cfg_q.rot_sin       <= '0;
			cfg_q.altitude_gain <= 16'sd256;
			cfg_q.zoom_gain     <= 16'd256;
			cfg_q.shift_x       <= '0;
			cfg_q.shift_y       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROT_COS:       cfg_q.rot_cos       <= cfg_data;
				REG_ROT_SIN:       cfg_q.rot_sin       <= cfg_data;
				REG_ALTITUDE_GAIN: cfg_q.altitude_gain <= cfg_data;
				REG_ZOOM_GAIN:     cfg_q.zoom_gain     <= cfg_data;
				REG_SHIFT_X:       cfg_q.shift_x       <= cfg_data;
				REG_SHIFT_Y:       cfg_q.shift_y       <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/ivt_rotate.sv -----
// Stages 1 and 2: rotation about the z axis and height scaling.
`timescale 1ns / 1ps

module ivt_rotate (
	input  logic                clk,
	input  logic                arst_n,
	input  ivt_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [12:0]  vert_x,
	input  logic signed [12:0]  vert_y,
	input  logic signed [15:0]  vert_z,
	input  logic        [23:0]  vert_color,
	output logic                out_valid,
	input  logic                out_ready,
	output ivt_pkg::rot_t       rot
);
	import ivt_pkg::*;

	logic v_s1, v_s2;
	logic en_s1, en_s2;

	logic signed [28:0] p_cx_s1, p_sy_s1, p_sx_s1, p_cy_s1;
	logic signed [31:0] az_s1;
	logic        [23:0] color_s1;
	rot_t               rot_s2;

	logic signed [29:0] rx, ry;

	assign en_s2    = ~v_s2 | out_ready;
	assign en_s1    = ~v_s1 | en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			p_cx_s1  <= 29'(cfg.rot_cos) * 29'(vert_x);
			p_sy_s1  <= 29'(cfg.rot_sin) * 29'(vert_y);
			p_sx_s1  <= 29'(cfg.rot_sin) * 29'(vert_x);
			p_cy_s1  <= 29'(cfg.rot_cos) * 29'(vert_y);
			az_s1    <= 32'(cfg.altitude_gain) * 32'(vert_z);
			color_s1 <= vert_color;
		end
	end

	assign rx = 30'(p_cx_s1) - 30'(p_sy_s1);
	assign ry = 30'(p_sx_s1) + 30'(p_cy_s1);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			rot_s2.diff  <= 31'(ry) - 31'(rx);
			rot_s2.sum   <= 31'(ry) + 31'(rx);
			rot_s2.az    <= az_s1;
			rot_s2.color <= color_s1;
		end
	end

	assign out_valid = v_s2;
	assign rot       = rot_s2;

endmodule

// ----- hw/rtl/ivt_project.sv -----
// Stages 3 and 4: isometric projection with rounding to Q.16.
`timescale 1ns / 1ps

module ivt_project (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ivt_pkg::rot_t  rot,
	output logic           out_valid,
	input  logic           out_ready,
	output ivt_pkg::proj_t proj
);
	import ivt_pkg::*;

	localparam logic signed [46:0] RND13 = 47'sd4096;

	logic v_s3, v_s4;
	logic en_s3, en_s4;

	logic signed [46:0] prod_s3;
	logic signed [41:0] npy_s3;
	logic        [23:0] color_s3;
	proj_t              proj_s4;

	logic signed [46:0] prod_rnd;

	assign en_s4    = ~v_s4 | out_ready;
	assign en_s3    = ~v_s3 | en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// cos30 * (ry - rx) is rounded by 13 bits; sin30 * (rx + ry) in Q.16 is exactly twice the sum; keep -py
	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			prod_s3  <= 47'(COS30_Q15) * 47'(rot.diff);
			npy_s3   <= (42'(rot.sum) <<< 1) - (42'(rot.az) <<< 8);
			color_s3 <= rot.color;
		end
	end

	assign prod_rnd = prod_s3 + RND13;

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			proj_s4.px    <= prod_rnd[46:13];
			proj_s4.npy   <= npy_s3;
			proj_s4.color <= color_s3;
		end
	end

	assign out_valid = v_s4;
	assign proj      = proj_s4;

endmodule

// ----- hw/rtl/ivt_zoom.sv -----
// Stages 5 to 7: zoom in split partial products, rounding, offset and saturation.
`timescale 1ns / 1ps

module ivt_zoom (
	input  logic                clk,
	input  logic                arst_n,
	input  ivt_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  ivt_pkg::proj_t      proj,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  screen_x,
	output logic signed [15:0]  screen_y,
	output logic        [23:0]  pixel_color
);
	import ivt_pkg::*;

	localparam logic [51:0] RND24_X = 52'd8388608;
	localparam logic [59:0] RND24_Y = 60'd8388608;

	logic v_s5, v_s6, v_s7;
	logic en_s5, en_s6, en_s7;

	logic        [32:0] lo_x_s5, lo_y_s5;
	logic signed [33:0] hi_x_s5;
	logic signed [41:0] hi_y_s5;
	logic        [23:0] color_s5, color_s6, color_s7;
	logic        [51:0] full_x_s6;
	logic        [59:0] full_y_s6;
	logic signed [15:0] sx_s7, sy_s7;

	logic signed [16:0] zoom_s;
	logic signed [27:0] rnd_x;
	logic signed [35:0] rnd_y;
	logic signed [29:0] sum_x;
	logic signed [37:0] sum_y;
	logic signed [15:0] sat_x, sat_y;

	assign en_s7    = ~v_s7 | out_ready;
	assign en_s6    = ~v_s6 | en_s7;
	assign en_s5    = ~v_s5 | en_s6;
	assign in_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	assign zoom_s = $signed({1'b0, cfg.zoom_gain});

	// Split each coordinate into an unsigned low half and a signed high half
	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			lo_x_s5  <= 33'(proj.px[16:0]) * 33'(cfg.zoom_gain);
			hi_x_s5  <= 34'($signed(proj.px[33:17])) * 34'(zoom_s);
			lo_y_s5  <= 33'(proj.npy[16:0]) * 33'(cfg.zoom_gain);
			hi_y_s5  <= 42'($signed(proj.npy[41:17])) * 42'(zoom_s);
			color_s5 <= proj.color;
		end
	end

	// Recombine and add the rounding half for the 24 bit drop
	always_ff @(posedge clk) begin
		if (en_s6 && v_s5) begin
			full_x_s6 <= {hi_x_s5[33], hi_x_s5, 17'd0} + {19'd0, lo_x_s5} + RND24_X;
			full_y_s6 <= {hi_y_s5[41], hi_y_s5, 17'd0} + {27'd0, lo_y_s5} + RND24_Y;
			color_s6  <= color_s5;
		end
	end

	assign rnd_x = $signed(full_x_s6[51:24]);
	assign rnd_y = $signed(full_y_s6[59:24]);
	assign sum_x = 30'(rnd_x) + 30'(cfg.shift_x) + 30'(CENTRE_X);
	assign sum_y = 38'(rnd_y) + 38'(cfg.shift_y) + 38'(CENTRE_Y);

	always_comb begin
		if (sum_x > 30'(SAT_MAX))      sat_x = 16'(SAT_MAX);
		else if (sum_x < 30'(SAT_MIN)) sat_x = 16'(SAT_MIN);
		else                           sat_x = sum_x[15:0];
		if (sum_y > 38'(SAT_MAX))      sat_y = 16'(SAT_MAX);
		else if (sum_y < 38'(SAT_MIN)) sat_y = 16'(SAT_MIN);
		else                           sat_y = sum_y[15:0];
	end

	always_ff @(posedge clk) begin
		if (en_s7 && v_s6) begin
			sx_s7    <= sat_x;
			sy_s7    <= sat_y;
			color_s7 <= color_s6;
		end
	end

	assign out_valid   = v_s7;
	assign screen_x    = sx_s7;
	assign screen_y    = sy_s7;
	assign pixel_color = color_s7;

endmodule

// ----- hw/rtl/isometric_vertex_transform.sv -----
// Top level of the isometric vertex transform: register file and seven-stage datapath.
`timescale 1ns / 1ps

// One vertex enters per clock while the output is not stalled and passes the seven
// register stages of the datapath (two for rotation, two for projection, three for
// zoom, offset and saturation). Every stage holds its own valid bit and takes a new
// transfer whenever it is empty or its successor moves, so bubbles close up and a
// stall on the output holds the pipe without loss. With the output ready the sustained
// rate is one vertex per cycle. The user must write configuration only while the pipe
// is empty, which the block does not enforce; a write applies to every later vertex.
module isometric_vertex_transform (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ivt_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// vert_x[12:0], vert_y[25:13], vert_z[41:26], vert_color[65:42], zero fill
	input  logic [71:0]                   s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// screen_x[15:0], screen_y[31:16], pixel_color[55:32]
	output logic [55:0]                   m_axis_tdata
);
	import ivt_pkg::*;

	cfg_t  cfg;
	rot_t  rot;
	proj_t proj;
	logic  rot_valid, rot_ready;
	logic  proj_valid, proj_ready;
	logic signed [15:0] screen_x, screen_y;
	logic        [23:0] pixel_color;

	ivt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ivt_rotate u_rotate (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.vert_x     ($signed(s_axis_tdata[12:0])),
		.vert_y     ($signed(s_axis_tdata[25:13])),
		.vert_z     ($signed(s_axis_tdata[41:26])),
		.vert_color (s_axis_tdata[65:42]),
		.out_valid  (rot_valid),
		.out_ready  (rot_ready),
		.rot        (rot)
	);

	ivt_project u_project (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rot_valid),
		.in_ready  (rot_ready),
		.rot       (rot),
		.out_valid (proj_valid),
		.out_ready (proj_ready),
		.proj      (proj)
	);

	ivt_zoom u_zoom (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (proj_valid),
		.in_ready    (proj_ready),
		.proj        (proj),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.screen_x    (screen_x),
		.screen_y    (screen_y),
		.pixel_color (pixel_color)
	);

	assign m_axis_tdata = {pixel_color, screen_y, screen_x};

	// Input back-pressure only when every stage is full and the output is stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && rot_valid && proj_valid))
		else $error("input stalled with room in the pipeline");

	a_cfg_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index > REG_SHIFT_Y) |=> $stable(cfg))
		else $error("write beyond the register list changed configuration");

	a_cfg_zoom: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_ZOOM_GAIN) |=> (cfg.zoom_gain == $past(cfg_data)))
		else $error("zoom gain write not taken");

endmodule
